FILE: hw/rtl/scc_pkg.sv
// Package for the sensor frame CRC check and conversion block: beat types, constants, CRC-8 update.
package scc_pkg;

    // CRC-8 used by the sensor: polynomial 0x31, initial value 0xFF, MSB first.
    localparam logic [7:0] CRC_GEN  = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // Frame modes held in the configuration register.
    localparam logic MODE_MEAS = 1'b0;
    localparam logic MODE_STAT = 1'b1;

    // Frame lengths in bytes.
    localparam logic [2:0] MEAS_LEN = 3'd6;
    localparam logic [2:0] STAT_LEN = 3'd3;

    // Byte positions within a frame.
    localparam logic [2:0] POS_W0_HI  = 3'd0;
    localparam logic [2:0] POS_W0_LO  = 3'd1;
    localparam logic [2:0] POS_W0_CRC = 3'd2;
    localparam logic [2:0] POS_W1_HI  = 3'd3;
    localparam logic [2:0] POS_W1_LO  = 3'd4;
    localparam logic [2:0] POS_W1_CRC = 3'd5;

    // Conversion constants: hundredths of a degree and of a percent over full scale 65535.
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    // One input beat.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_beat_t;

    // One result beat.
    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [15:0]        status_raw;
        logic               temperature_valid;
        logic               humidity_valid;
        logic               status_valid;
        logic               frame_ok;
    } out_beat_t;

    // Fold one byte into the running CRC, one bit per step.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = (c << 1) ^ CRC_GEN;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/sensor_frame_crc_check_convert.sv
// Top level: frame tracking, CRC check, scaling of raw sensor words and result output.
//
//   Channel  | Ports                         | Carries
//   ---------+-------------------------------+----------------------------------------
//   input    | s_valid, s_ready, s_data      | one received byte and its frame start flag
//   result   | m_valid, m_ready, m_data      | converted values with per-word valid flags
//   config   | cfg_wr_en, cfg_wr_data        | frame mode (0 measurement, 1 status)
//
// One byte is accepted per cycle while s_ready is high. The CRC byte update and frame
// bookkeeping happen at the accepting edge; the last byte of a frame launches the scaling
// multiplies into a product register, and the divide-by-65535 correction then fills the
// output register. Reset leaves the block at byte 0 of a frame in measurement mode.
// A stalled result holds the output register; input beats keep flowing until the
// product register is also occupied.
module sensor_frame_crc_check_convert (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  scc_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output scc_pkg::out_beat_t m_data,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);
    import scc_pkg::*;

    // Frame tracking state.
    logic        mode_reg;
    logic [2:0]  pos_reg,        pos_next;
    logic [7:0]  crc_reg,        crc_next;
    logic [7:0]  high_byte_reg,  high_byte_next;
    logic [15:0] word0_reg,      word0_next;
    logic [15:0] word1_reg,      word1_next;
    logic        word0_ok_reg,   word0_ok_next;

    // Product stage.
    logic        st1_valid_reg;
    logic        st1_mode_reg;
    logic [30:0] t_prod_reg;
    logic [29:0] h_prod_reg;
    logic [15:0] st1_status_reg;
    logic        st1_t_ok_reg;
    logic        st1_h_ok_reg;
    logic        st1_s_ok_reg;

    // Output stage.
    logic        m_valid_reg;
    out_beat_t   m_data_reg, m_data_next;

    logic        s_accept;
    logic        out_free;
    logic        st1_adv;
    logic [2:0]  frame_len;
    logic [2:0]  pos;
    logic        last_byte;
    logic        crc_match;
    logic [7:0]  crc_of_byte;
    logic [7:0]  crc_from_init;

    // Handshake: the product stage drains into a free output register.
    assign out_free = !m_valid_reg || m_ready;
    assign st1_adv  = st1_valid_reg && out_free;
    assign s_ready  = !st1_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Position of this beat in the frame; a start flag or an out-of-range position restarts.
    assign frame_len = (mode_reg == MODE_STAT) ? STAT_LEN : MEAS_LEN;
    assign pos       = (s_data.frame_start || pos_reg >= frame_len) ? POS_W0_HI : pos_reg;
    assign last_byte = (pos + 3'd1) == frame_len;

    // CRC updates and the check against the received CRC byte.
    assign crc_of_byte   = crc8_update(crc_reg, s_data.rx_byte);
    assign crc_from_init = crc8_update(CRC_INIT, s_data.rx_byte);
    assign crc_match     = crc_reg == s_data.rx_byte;

    // Per-byte bookkeeping.
    always_comb begin
        crc_next       = crc_reg;
        high_byte_next = high_byte_reg;
        word0_next     = word0_reg;
        word1_next     = word1_reg;
        word0_ok_next  = word0_ok_reg;
        unique case (pos) inside
            POS_W0_HI, POS_W1_HI: begin
                crc_next       = crc_from_init;
                high_byte_next = s_data.rx_byte;
            end
            POS_W0_LO: begin
                crc_next   = crc_of_byte;
                word0_next = {high_byte_reg, s_data.rx_byte};
            end
            POS_W1_LO: begin
                crc_next   = crc_of_byte;
                word1_next = {high_byte_reg, s_data.rx_byte};
            end
            POS_W0_CRC: begin
                word0_ok_next = crc_match;
            end
            default: begin
            end
        endcase
        pos_next = last_byte ? POS_W0_HI : pos + 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_MEAS;
            pos_reg       <= POS_W0_HI;
            crc_reg       <= CRC_INIT;
            high_byte_reg <= '0;
            word0_reg     <= '0;
            word1_reg     <= '0;
            word0_ok_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                pos_reg       <= pos_next;
                crc_reg       <= crc_next;
                high_byte_reg <= high_byte_next;
                word0_reg     <= word0_next;
                word1_reg     <= word1_next;
                word0_ok_reg  <= word0_ok_next;
            end
        end
    end

    // Product stage: the last byte launches both scaling multiplies.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_accept && last_byte) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_adv) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && last_byte) begin
            st1_mode_reg   <= mode_reg;
            t_prod_reg     <= {15'd0, word0_reg} * {16'd0, TEMP_SCALE};
            h_prod_reg     <= {14'd0, word1_reg} * {16'd0, HUM_SCALE};
            st1_status_reg <= word0_reg;
            st1_t_ok_reg   <= word0_ok_reg;
            st1_h_ok_reg   <= crc_match;
            st1_s_ok_reg   <= crc_match;
        end
    end

    // Output stage: floor(x / 65535) = hi + (hi + lo >= 65535), with hi = x >> 16.
    always_comb begin
        logic [16:0] t_rem;
        logic [16:0] h_rem;
        logic [14:0] t_quot;
        logic [13:0] h_quot;
        t_rem  = {2'b00, t_prod_reg[30:16]} + {1'b0, t_prod_reg[15:0]};
        h_rem  = {3'b000, h_prod_reg[29:16]} + {1'b0, h_prod_reg[15:0]};
        t_quot = t_prod_reg[30:16] + {14'd0, t_rem >= FULL_SCALE};
        h_quot = h_prod_reg[29:16] + {13'd0, h_rem >= FULL_SCALE};
        m_data_next = '0;
        if (st1_mode_reg == MODE_STAT) begin
            if (st1_s_ok_reg) begin
                m_data_next.status_raw   = st1_status_reg;
                m_data_next.status_valid = 1'b1;
                m_data_next.frame_ok     = 1'b1;
            end
        end else begin
            if (st1_t_ok_reg) begin
                m_data_next.temperature_centi = $signed(t_quot - TEMP_OFFSET);
                m_data_next.temperature_valid = 1'b1;
            end
            if (st1_h_ok_reg) begin
                m_data_next.humidity_centi = h_quot;
                m_data_next.humidity_valid = 1'b1;
            end
            m_data_next.frame_ok = st1_t_ok_reg && st1_h_ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            m_data_reg <= m_data_next;
        end
    end

    // Input is only held off while both result stages are full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (st1_valid_reg && m_valid_reg))
        else $error("input stalled with a free result stage");

    // The frame position never leaves the six-byte range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W1_CRC)
        else $error("frame position out of range");

    // The last byte of a frame always lands in the product stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && last_byte) |=> st1_valid_reg)
        else $error("frame end lost");

    // frame_ok agrees with the per-word flags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.frame_ok) |->
            (m_data_reg.status_valid ||
             (m_data_reg.temperature_valid && m_data_reg.humidity_valid)))
        else $error("frame_ok without matching word flags");

endmodule

FILE: bench/tb_sensor_frame_crc_check_convert.sv
// Self-checking testbench for the sensor frame CRC check and conversion block.
module tb_sensor_frame_crc_check_convert;
    timeunit 1ns;
    timeprecision 1ps;

    import scc_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_REPORTS = 50;

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    in_beat_t  s_data      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    out_beat_t m_data;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;

    // Byte beats waiting to be driven and results waiting to be seen.
    in_beat_t  pending_bytes[$];
    out_beat_t expected_results[$];

    int bytes_queued = 0;
    int bytes_taken  = 0;
    int result_index = 0;
    int fail_count   = 0;
    int quiet_cycles = 0;

    // Idling controls, set per phase by the stimulus process.
    logic send_idle  = 1'b1;
    logic recv_idle  = 1'b1;
    int   send_gap   = 0;
    int   recv_wait  = 0;
    int   hold_left  = 0;
    int   stall_reqs = 0;
    int   stall_seen = 0;
    logic beat_taken   = 1'b0;
    logic result_taken = 1'b0;

    // Frame tracker state mirrored from the block.
    logic        mode_copy  = MODE_MEAS;
    logic [2:0]  frame_pos  = POS_W0_HI;
    logic [7:0]  crc_acc    = CRC_INIT;
    logic [7:0]  hi_byte    = 8'h00;
    logic [15:0] word_a     = 16'h0000;
    logic [15:0] word_b     = 16'h0000;
    logic        word_a_ok  = 1'b0;

    sensor_frame_crc_check_convert dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    // CRC-8, polynomial 0x31, MSB first, shifted one bit at a time.
    function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_GEN) : {r[6:0], 1'b0};
        return r;
    endfunction

    // Advance the frame tracker by one accepted byte; on the last byte of a frame
    // the converted result is queued.
    task automatic track_frame_byte(input in_beat_t beat);
        logic [2:0]  len;
        logic [2:0]  pos;
        logic [31:0] scaled;
        logic        last_ok;
        out_beat_t   r;
        len = (mode_copy == MODE_STAT) ? STAT_LEN : MEAS_LEN;
        pos = frame_pos;
        if (beat.frame_start || pos >= len) begin
            pos = POS_W0_HI;
        end
        case (pos) inside
            POS_W0_HI, POS_W1_HI: begin
                crc_acc = crc8_fold(CRC_INIT, beat.rx_byte);
                hi_byte = beat.rx_byte;
            end
            POS_W0_LO: begin
                crc_acc = crc8_fold(crc_acc, beat.rx_byte);
                word_a  = {hi_byte, beat.rx_byte};
            end
            POS_W1_LO: begin
                crc_acc = crc8_fold(crc_acc, beat.rx_byte);
                word_b  = {hi_byte, beat.rx_byte};
            end
            POS_W0_CRC: begin
                word_a_ok = (crc_acc == beat.rx_byte);
            end
            default: ;
        endcase
        if ({1'b0, pos} + 4'd1 < {1'b0, len}) begin
            frame_pos = pos + 3'd1;
        end else begin
            frame_pos = POS_W0_HI;
            r = '0;
            if (mode_copy == MODE_STAT) begin
                if (word_a_ok) begin
                    r.status_raw   = word_a;
                    r.status_valid = 1'b1;
                    r.frame_ok     = 1'b1;
                end
            end else begin
                last_ok = (crc_acc == beat.rx_byte);
                if (word_a_ok) begin
                    scaled = ({16'd0, word_a} * 32'(TEMP_SCALE)) / 32'(FULL_SCALE);
                    r.temperature_centi = 15'(scaled - 32'(TEMP_OFFSET));
                    r.temperature_valid = 1'b1;
                end
                if (last_ok) begin
                    scaled = ({16'd0, word_b} * 32'(HUM_SCALE)) / 32'(FULL_SCALE);
                    r.humidity_centi = 14'(scaled);
                    r.humidity_valid = 1'b1;
                end
                r.frame_ok = word_a_ok && last_ok;
            end
            expected_results.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_REPORTS) begin
            $display("[%0t] result %0d: %s", $realtime, result_index, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic start);
        in_beat_t beat;
        beat.rx_byte     = b;
        beat.frame_start = start;
        pending_bytes.push_back(beat);
        bytes_queued++;
    endtask

    // Queue one frame (or its first keep bytes); bad flips the CRC of word 0 and/or 1.
    task automatic queue_frame(input logic stat, input logic [15:0] w0, input logic [15:0] w1,
                               input logic [1:0] bad, input logic mark, input int keep);
        logic [7:0] fb[6];
        int         n;
        fb[0] = w0[15:8];
        fb[1] = w0[7:0];
        fb[2] = crc8_fold(crc8_fold(CRC_INIT, fb[0]), fb[1]);
        fb[3] = w1[15:8];
        fb[4] = w1[7:0];
        fb[5] = crc8_fold(crc8_fold(CRC_INIT, fb[3]), fb[4]);
        if (bad[0]) fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
        if (bad[1]) fb[5] = fb[5] ^ 8'($urandom_range(1, 255));
        n = stat ? int'(STAT_LEN) : int'(MEAS_LEN);
        if (keep < n) n = keep;
        for (int i = 0; i < n; i++) begin
            queue_byte(fb[i], (i == 0) && mark);
        end
    endtask

    function automatic logic [15:0] sensor_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly clean frames with random words, mixed with corrupted CRCs, cut frames and noise.
    task automatic queue_random_bytes(input int count, input logic stat);
        int first;
        int pick;
        first = bytes_queued;
        while (bytes_queued - first < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                queue_frame(stat, sensor_word(), sensor_word(), 2'b00,
                            $urandom_range(0, 9) != 0, 6);
            end else if (pick < 85) begin
                queue_frame(stat, sensor_word(), sensor_word(), 2'($urandom_range(1, 3)),
                            1'b1, 6);
            end else if (pick < 93) begin
                queue_frame(stat, sensor_word(), sensor_word(), 2'b00, 1'b1,
                            $urandom_range(1, stat ? 2 : 5));
            end else begin
                queue_byte(8'($urandom), 1'($urandom));
            end
        end
    endtask

    // Wait until every byte is in, every result is out, and the pipeline has drained.
    task automatic wait_idle();
        wait (bytes_taken == bytes_queued);
        wait (expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_mode(input logic m);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        mode_copy    = m;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Input side: record accepted beats and run them through the tracker.
    always @(posedge aclk) begin
        beat_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            track_frame_byte(s_data);
            bytes_taken++;
        end
    end

    // Input driver: hold a beat until taken, then idle or offer the next one.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !beat_taken) begin
            s_valid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap--;
            s_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
            s_data   <= pending_bytes.pop_front();
            s_valid  <= 1'b1;
            send_gap  = send_idle ? $urandom_range(0, 9) : 0;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result monitor: compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin : result_check
        out_beat_t want;
        result_taken <= aresetn && m_valid && m_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result arrived with nothing expected");
            end else begin
                want = expected_results.pop_front();
                check_field("temperature_centi", m_data.temperature_centi,
                            want.temperature_centi);
                check_field("humidity_centi", m_data.humidity_centi, want.humidity_centi);
                check_field("status_raw", m_data.status_raw, want.status_raw);
                check_field("temperature_valid", m_data.temperature_valid,
                            want.temperature_valid);
                check_field("humidity_valid", m_data.humidity_valid, want.humidity_valid);
                check_field("status_valid", m_data.status_valid, want.status_valid);
                check_field("frame_ok", m_data.frame_ok, want.frame_ok);
            end
            result_index++;
        end
    end

    // Result receiver: a random wait per beat, and a long hold-off when requested.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_seen != stall_reqs) begin
                stall_seen = stall_reqs;
                hold_left  = LONG_HOLD;
            end
            if (result_taken) begin
                recv_wait = recv_idle ? $urandom_range(0, 9) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any beat on either channel ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial begin : stimulus
        logic mode;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Measurement mode from reset: full-scale words, bad CRCs, missing and early marks.
        queue_frame(MODE_MEAS, 16'h0000, 16'hFFFF, 2'b00, 1'b1, 6);
        queue_frame(MODE_MEAS, 16'hFFFF, 16'h0000, 2'b01, 1'b0, 6);
        queue_frame(MODE_MEAS, 16'h6666, 16'h8000, 2'b00, 1'b1, 1);
        queue_frame(MODE_MEAS, 16'h8000, 16'h7FFF, 2'b10, 1'b1, 6);
        // Leave a frame half done so the switch to status mode restarts it.
        queue_frame(MODE_MEAS, 16'h1234, 16'h5678, 2'b00, 1'b1, 3);
        wait_idle();
        write_mode(MODE_STAT);
        queue_frame(MODE_STAT, 16'hFFFF, 16'h0000, 2'b00, 1'b0, 3);
        queue_frame(MODE_STAT, 16'h0000, 16'h0000, 2'b01, 1'b1, 3);

        // Random phases, each starting from an idle block with its own mode and idling.
        for (int p = 0; p < 10; p++) begin
            wait_idle();
            mode = (p == 0) ? MODE_MEAS : (p == 1) ? MODE_STAT : 1'($urandom);
            write_mode(mode);
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            if (p == 2) begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end
            if (p == 3) begin
                // Receiver stalls long while bytes keep coming, to back up the input.
                send_idle = 1'b0;
                stall_reqs++;
            end
            queue_random_bytes(90, mode);
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/scc_pkg.sv
hw/rtl/sensor_frame_crc_check_convert.sv
bench/tb_sensor_frame_crc_check_convert.sv
